### design/cnw_pkg.sv
package cnw_pkg;

    localparam int HOLD_LEN = 9;
    localparam int HDR_LEN  = 110;

    localparam logic [1:0] KIND_NAME_BYTE = 2'd0;
    localparam logic [1:0] KIND_NAME_END  = 2'd1;
    localparam logic [1:0] KIND_ARC_END   = 2'd2;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd3;

    // all results caused by one archive byte: held name bytes, then an optional record
    typedef struct packed {
        logic [3:0]                    nbytes;
        logic [HOLD_LEN-1:0][7:0]      bytes;
        logic                          rec_valid;
        logic [1:0]                    rec_kind;
        logic [31:0]                   rec_size;
        logic [15:0]                   index;
    } cnw_bundle_t;

endpackage

### design/cpio_newc_entry_walker_core.sv
// output: the first result of an archive byte shows on m_* in the cycle after it is accepted
// throughput: one byte per cycle while each byte gives at most one result and m_ready is
//   high; a byte that gives k results (up to ten, when held name bytes are released) holds
//   off the next byte until its last result is taken from the single result register
// reset: synchronous active-low aresetn returns the walker to the start of a header;
//   the name lookahead bytes are not reset
module cpio_newc_entry_walker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_archive_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_name_byte,
    output logic [31:0] m_file_size,
    output logic [15:0] m_entry_index,
    output logic        m_last
);
    import cnw_pkg::*;

    cnw_bundle_t bundle;
    logic        fire;
    logic        can_load;
    logic        load;

    assign s_ready = can_load;
    assign fire    = s_valid && s_ready;
    // bytes with no result only advance the parser
    assign load    = fire && (bundle.nbytes != 4'd0 || bundle.rec_valid);

    cnw_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .archive_byte (s_archive_byte),
        .bundle       (bundle)
    );

    cnw_emitter u_emitter (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .bundle        (bundle),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_name_byte   (m_name_byte),
        .m_file_size   (m_file_size),
        .m_entry_index (m_entry_index),
        .m_last        (m_last)
    );

endmodule

### design/cnw_parser.sv
module cnw_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          archive_byte,
    output cnw_pkg::cnw_bundle_t bundle
);
    import cnw_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAME_PAD,
        PH_DATA,
        PH_DATA_PAD,
        PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] hex_accum_reg, hex_accum_next;
    logic [31:0] name_size_reg, name_size_next;
    logic [31:0] data_size_reg, data_size_next;
    logic [3:0]  la_count_reg, la_count_next;
    logic        trailer_match_reg, trailer_match_next;
    logic        magic_ok_reg, magic_ok_next;
    logic        name_done_reg, name_done_next;
    logic [15:0] entry_count_reg, entry_count_next;
    logic [7:0]  la_reg [HOLD_LEN];
    logic [7:0]  la_new [HOLD_LEN];

    logic [31:0] hex_base;
    logic [31:0] pad_len;
    logic [31:0] bc_inc;
    logic [3:0]  flush_len;
    logic [3:0]  flush_cnt;
    logic        do_flush;
    logic        do_name_end;
    logic        last_name_byte;

    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = "0";
            3'd1: c = "7";
            3'd2: c = "0";
            3'd3: c = "7";
            3'd4: c = "0";
            3'd5: c = "1";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = "T";
            4'd1: c = "R";
            4'd2: c = "A";
            4'd3: c = "I";
            4'd4: c = "L";
            4'd5: c = "E";
            4'd6: c = "R";
            4'd7: c = "!";
            4'd8: c = "!";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // non-hex bytes still add (byte - '0') modulo 2^32
    function automatic logic [31:0] hex_digit(input logic [7:0] b);
        logic [31:0] d;
        if (b >= "A" && b <= "F") begin
            d = 32'(b - "A") + 32'd10;
        end else if (b >= "a" && b <= "f") begin
            d = 32'(b - "a") + 32'd10;
        end else begin
            d = {24'd0, b} - 32'd48;
        end
        return d;
    endfunction

    // first non-empty phase at or after p
    function automatic phase_t enter_phase(input phase_t p, input logic [31:0] ns,
                                           input logic [31:0] ds);
        phase_t q;
        logic [1:0] npad;
        logic [1:0] dpad;
        npad = 2'd2 - ns[1:0];
        dpad = 2'd0 - ds[1:0];
        unique case (p)
            PH_NAME_PAD: q = (npad != 2'd0) ? PH_NAME_PAD :
                             (ds != 32'd0) ? PH_DATA : PH_HEADER;
            PH_DATA:     q = (ds != 32'd0) ? PH_DATA : PH_HEADER;
            PH_DATA_PAD: q = (dpad != 2'd0) ? PH_DATA_PAD : PH_HEADER;
            default:     q = PH_HEADER;
        endcase
        return q;
    endfunction

    always_comb begin
        for (int j = 0; j < HOLD_LEN; j++) begin
            la_new[j] = (4'(j) == la_count_reg) ? archive_byte : la_reg[j];
        end
    end

    assign bc_inc         = byte_count_reg + 32'd1;
    assign last_name_byte = (bc_inc == name_size_reg);

    always_comb begin
        unique case (phase_reg)
            PH_NAME_PAD: pad_len = {30'd0, 2'd2 - name_size_reg[1:0]};
            PH_DATA:     pad_len = data_size_reg;
            PH_DATA_PAD: pad_len = {30'd0, 2'd0 - data_size_reg[1:0]};
            default:     pad_len = 32'd1;
        endcase
    end

    // count of held bytes ahead of the first zero
    always_comb begin
        flush_cnt = la_count_reg + 4'd1;
        for (int j = HOLD_LEN - 1; j >= 0; j--) begin
            if (4'(j) <= la_count_reg && la_new[j] == 8'd0) begin
                flush_cnt = 4'(j);
            end
        end
    end

    always_comb begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        hex_accum_next     = hex_accum_reg;
        name_size_next     = name_size_reg;
        data_size_next     = data_size_reg;
        la_count_next      = la_count_reg;
        trailer_match_next = trailer_match_reg;
        magic_ok_next      = magic_ok_reg;
        name_done_next     = name_done_reg;
        entry_count_next   = entry_count_reg;
        hex_base           = 32'd0;
        flush_len          = 4'd0;
        do_flush           = 1'b0;
        do_name_end        = 1'b0;

        for (int j = 0; j < HOLD_LEN; j++) begin
            bundle.bytes[j] = la_new[j];
        end
        bundle.nbytes    = 4'd0;
        bundle.rec_valid = 1'b0;
        bundle.rec_kind  = KIND_NAME_END;
        bundle.rec_size  = 32'd0;
        bundle.index     = entry_count_reg;

        unique case (phase_reg)
            PH_HEADER: begin
                if (byte_count_reg < 32'd6 &&
                        archive_byte != magic_char(byte_count_reg[2:0])) begin
                    magic_ok_next = 1'b0;
                end
                if (byte_count_reg == 32'd5 && !magic_ok_next) begin
                    bundle.rec_valid = 1'b1;
                    bundle.rec_kind  = KIND_BAD_MAGIC;
                    phase_next       = PH_STOP;
                end else begin
                    if ((byte_count_reg >= 32'd54 && byte_count_reg <= 32'd61) ||
                            (byte_count_reg >= 32'd94 && byte_count_reg <= 32'd101)) begin
                        hex_base = (byte_count_reg == 32'd54 || byte_count_reg == 32'd94) ?
                                   32'd0 : hex_accum_reg;
                        hex_accum_next = {hex_base[27:0], 4'd0} + hex_digit(archive_byte);
                        if (byte_count_reg == 32'd61) begin
                            data_size_next = hex_accum_next;
                        end
                        if (byte_count_reg == 32'd101) begin
                            name_size_next = hex_accum_next;
                        end
                    end
                    if (byte_count_reg == 32'(HDR_LEN - 1)) begin
                        la_count_next      = 4'd0;
                        trailer_match_next = 1'b1;
                        name_done_next     = 1'b0;
                        if (name_size_reg == 32'd0) begin
                            do_name_end = 1'b1;
                        end else begin
                            phase_next      = PH_NAME;
                            byte_count_next = 32'd0;
                        end
                    end else begin
                        byte_count_next = bc_inc;
                    end
                end
            end
            PH_NAME: begin
                if (la_count_reg < 4'(HOLD_LEN)) begin
                    trailer_match_next = trailer_match_reg &&
                                         (archive_byte == trailer_char(la_count_reg));
                    la_count_next = la_count_reg + 4'd1;
                    if (la_count_next == 4'(HOLD_LEN)) begin
                        if (trailer_match_next) begin
                            bundle.rec_valid = 1'b1;
                            bundle.rec_kind  = KIND_ARC_END;
                            phase_next       = PH_STOP;
                        end else begin
                            do_flush  = 1'b1;
                            flush_len = la_count_next;
                        end
                    end else if (last_name_byte) begin
                        do_flush  = 1'b1;
                        flush_len = la_count_next;
                    end
                    if (do_flush) begin
                        bundle.nbytes  = flush_cnt;
                        name_done_next = (flush_cnt != flush_len);
                    end
                end else if (!name_done_reg) begin
                    if (archive_byte == 8'd0) begin
                        name_done_next = 1'b1;
                    end else begin
                        bundle.bytes[0] = archive_byte;
                        bundle.nbytes   = 4'd1;
                    end
                end
                if (phase_next != PH_STOP) begin
                    if (last_name_byte) begin
                        do_name_end = 1'b1;
                    end else begin
                        byte_count_next = bc_inc;
                    end
                end
            end
            PH_NAME_PAD, PH_DATA, PH_DATA_PAD: begin
                byte_count_next = bc_inc;
                if (bc_inc >= pad_len) begin
                    phase_next = enter_phase((phase_reg == PH_DATA_PAD) ? PH_HEADER :
                                             phase_t'(phase_reg + 3'd1),
                                             name_size_reg, data_size_reg);
                    byte_count_next = 32'd0;
                    if (phase_next == PH_HEADER) begin
                        magic_ok_next = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase

        if (do_name_end) begin
            bundle.rec_valid = 1'b1;
            bundle.rec_kind  = KIND_NAME_END;
            bundle.rec_size  = data_size_reg;
            if (entry_count_reg != 16'hFFFF) begin
                entry_count_next = entry_count_reg + 16'd1;
            end
            phase_next      = enter_phase(PH_NAME_PAD, name_size_reg, data_size_reg);
            byte_count_next = 32'd0;
            if (phase_next == PH_HEADER) begin
                magic_ok_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            byte_count_reg    <= 32'd0;
            hex_accum_reg     <= 32'd0;
            name_size_reg     <= 32'd0;
            data_size_reg     <= 32'd0;
            la_count_reg      <= 4'd0;
            trailer_match_reg <= 1'b1;
            magic_ok_reg      <= 1'b1;
            name_done_reg     <= 1'b0;
            entry_count_reg   <= 16'd0;
        end else if (fire) begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            hex_accum_reg     <= hex_accum_next;
            name_size_reg     <= name_size_next;
            data_size_reg     <= data_size_next;
            la_count_reg      <= la_count_next;
            trailer_match_reg <= trailer_match_next;
            magic_ok_reg      <= magic_ok_next;
            name_done_reg     <= name_done_next;
            entry_count_reg   <= entry_count_next;
        end
    end

    // lookahead bytes need no reset
    always_ff @(posedge aclk) begin
        if (fire && phase_reg == PH_NAME && la_count_reg < 4'(HOLD_LEN)) begin
            for (int j = 0; j < HOLD_LEN; j++) begin
                la_reg[j] <= la_new[j];
            end
        end
    end

endmodule

### design/cnw_emitter.sv
module cnw_emitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  cnw_pkg::cnw_bundle_t bundle,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_name_byte,
    output logic [31:0]          m_file_size,
    output logic [15:0]          m_entry_index,
    output logic                 m_last
);
    import cnw_pkg::*;

    logic [7:0]  bytes_reg [HOLD_LEN];
    logic [3:0]  nbytes_reg;
    logic        rec_valid_reg;
    logic [1:0]  rec_kind_reg;
    logic [31:0] rec_size_reg;
    logic [15:0] index_reg;
    logic        take;
    logic        has_byte;

    assign has_byte      = (nbytes_reg != 4'd0);
    assign m_valid       = has_byte || rec_valid_reg;
    assign m_last        = has_byte ? (nbytes_reg == 4'd1 && !rec_valid_reg) : 1'b1;
    assign m_kind        = has_byte ? KIND_NAME_BYTE : rec_kind_reg;
    assign m_name_byte   = has_byte ? bytes_reg[0] : 8'd0;
    assign m_file_size   = has_byte ? 32'd0 : rec_size_reg;
    assign m_entry_index = index_reg;
    assign take          = m_valid && m_ready;
    // a new request may enter as the final result of the previous one leaves
    assign can_load      = !m_valid || (m_ready && m_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbytes_reg    <= 4'd0;
            rec_valid_reg <= 1'b0;
        end else if (load) begin
            nbytes_reg    <= bundle.nbytes;
            rec_valid_reg <= bundle.rec_valid;
        end else if (take) begin
            if (has_byte) begin
                nbytes_reg <= nbytes_reg - 4'd1;
            end else begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int j = 0; j < HOLD_LEN; j++) begin
                bytes_reg[j] <= bundle.bytes[j];
            end
            rec_kind_reg <= bundle.rec_kind;
            rec_size_reg <= bundle.rec_size;
            index_reg    <= bundle.index;
        end else if (take && has_byte) begin
            for (int j = 0; j < HOLD_LEN - 1; j++) begin
                bytes_reg[j] <= bytes_reg[j + 1];
            end
        end
    end

endmodule

### design/cnw_checker.sv
module cnw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_archive_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_name_byte,
    input logic [31:0] m_file_size,
    input logic [15:0] m_entry_index,
    input logic        m_last
);
    import cnw_pkg::*;

    // a stalled result blocks the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_name_byte)
                                   && $stable(m_file_size) && $stable(m_entry_index)
                                   && $stable(m_last)))
        else $error("stalled result changed");

    // a waiting request keeps its byte
    a_request_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_archive_byte)))
        else $error("waiting request changed");

    // end of archive or bad magic ends the request and the walk
    a_stop_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_kind == KIND_ARC_END || m_kind == KIND_BAD_MAGIC))
        |-> m_last ##1 !m_valid)
        else $error("result after stop");

    a_name_byte_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_NAME_BYTE) |-> (m_name_byte != 8'd0 && m_file_size == 32'd0))
        else $error("bad name byte result");

endmodule

bind cpio_newc_entry_walker_core cnw_checker u_cnw_checker (.*);

### dv/testbench.sv
module testbench;
    import cnw_pkg::*;

    localparam logic [2:0] SEG_HEADER   = 3'd0;
    localparam logic [2:0] SEG_NAME     = 3'd1;
    localparam logic [2:0] SEG_NAME_PAD = 3'd2;
    localparam logic [2:0] SEG_DATA     = 3'd3;
    localparam logic [2:0] SEG_DATA_PAD = 3'd4;
    localparam logic [2:0] SEG_STOP     = 3'd5;

    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [71:0] TRAILER_TEXT = "TRAILER!!";
    localparam int          STALL_LIMIT  = 4000;
    localparam int          MAX_RECORDS  = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic [31:0] file_size;
        logic [15:0] entry_index;
        logic        last;
    } walk_record_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_archive_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [7:0]  m_name_byte;
    logic [31:0] m_file_size;
    logic [15:0] m_entry_index;
    logic        m_last;

    cpio_newc_entry_walker_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_archive_byte(s_archive_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_name_byte   (m_name_byte),
        .m_file_size   (m_file_size),
        .m_entry_index (m_entry_index),
        .m_last        (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    int errors = 0;
    int idle_run = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int walked_items = 0;

    walk_record_t pending_records[$];
    logic [7:0]   name_buf[$];

    // walker state as predicted
    logic [2:0]   seg = SEG_HEADER;
    logic [31:0]  seg_pos = 32'd0;
    logic [31:0]  hex_acc = 32'd0;
    logic [31:0]  name_len = 32'd0;
    logic [31:0]  data_len = 32'd0;
    logic [7:0]   held [HOLD_LEN];
    logic [3:0]   held_n = 4'd0;
    logic         trailer_like = 1'b1;
    logic         magic_good = 1'b1;
    logic [15:0]  entries_done = 16'd0;
    logic         name_ended = 1'b0;

    walk_record_t byte_records [MAX_RECORDS];
    int           byte_record_n = 0;

    function automatic logic [31:0] hex_value(input logic [7:0] b);
        logic [31:0] w;
        w = {24'h0, b};
        if (b >= 8'h41 && b <= 8'h46) return w - 32'h37;
        if (b >= 8'h61 && b <= 8'h66) return w - 32'h57;
        return w - 32'h30;
    endfunction

    function automatic logic [31:0] hex_text_value(input logic [63:0] txt);
        logic [31:0] acc;
        int k;
        acc = 32'd0;
        for (k = 7; k >= 0; k--) acc = (acc << 4) + hex_value(txt[8*k +: 8]);
        return acc;
    endfunction

    function automatic logic [31:0] seg_len(input logic [2:0] p);
        case (p)
            SEG_NAME_PAD: return (32'd4 - ((HDR_LEN + name_len) & 32'd3)) & 32'd3;
            SEG_DATA:     return data_len;
            SEG_DATA_PAD: return (32'd4 - (data_len & 32'd3)) & 32'd3;
            default:      return 32'd1;
        endcase
    endfunction

    function automatic void enter_seg(input logic [2:0] p);
        while (p != SEG_HEADER && seg_len(p) == 32'd0)
            p = (p == SEG_DATA_PAD) ? SEG_HEADER : p + 3'd1;
        seg = p;
        seg_pos = 32'd0;
        if (p == SEG_HEADER) magic_good = 1'b1;
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] nb,
                                 input logic [31:0] fs);
        walk_record_t r;
        r.kind = kind;
        r.name_byte = nb;
        r.file_size = fs;
        r.entry_index = entries_done;
        r.last = 1'b0;
        byte_records[byte_record_n] = r;
        byte_record_n++;
    endfunction

    function automatic void name_char(input logic [7:0] b);
        if (name_ended) return;
        if (b == 8'h00) name_ended = 1'b1;
        else emit(KIND_NAME_BYTE, b, 32'd0);
    endfunction

    function automatic void release_held();
        int k;
        for (k = 0; k < held_n && k < HOLD_LEN; k++) name_char(held[k]);
    endfunction

    function automatic void close_name();
        emit(KIND_NAME_END, 8'h00, data_len);
        if (entries_done != 16'hFFFF) entries_done++;
        enter_seg(SEG_NAME_PAD);
    endfunction

    // expected records caused by one accepted archive byte
    function automatic void walk_archive_byte(input logic [7:0] b);
        logic [31:0]  pos;
        logic [31:0]  base;
        logic         halted;
        walk_record_t r;
        int           k;
        pos = seg_pos;
        halted = 1'b0;
        byte_record_n = 0;
        case (seg)
            SEG_HEADER: begin
                if (pos < 6) begin
                    if (b != MAGIC_TEXT[8*(5-pos) +: 8]) magic_good = 1'b0;
                end
                if (pos == 5 && !magic_good) begin
                    emit(KIND_BAD_MAGIC, 8'h00, 32'd0);
                    seg = SEG_STOP;
                end else begin
                    if ((pos >= 54 && pos <= 61) || (pos >= 94 && pos <= 101)) begin
                        base = (pos == 54 || pos == 94) ? 32'd0 : hex_acc;
                        hex_acc = (base << 4) + hex_value(b);
                        if (pos == 61) data_len = hex_acc;
                        if (pos == 101) name_len = hex_acc;
                    end
                    if (pos == HDR_LEN - 1) begin
                        held_n = 4'd0;
                        trailer_like = 1'b1;
                        name_ended = 1'b0;
                        if (name_len == 32'd0) begin
                            close_name();
                        end else begin
                            seg = SEG_NAME;
                            seg_pos = 32'd0;
                        end
                    end else begin
                        seg_pos = seg_pos + 32'd1;
                    end
                end
            end
            SEG_NAME: begin
                if (held_n < HOLD_LEN) begin
                    held[held_n] = b;
                    if (b != TRAILER_TEXT[8*(8-held_n) +: 8]) trailer_like = 1'b0;
                    held_n = held_n + 4'd1;
                    if (held_n == HOLD_LEN) begin
                        if (trailer_like) begin
                            emit(KIND_ARC_END, 8'h00, 32'd0);
                            seg = SEG_STOP;
                            halted = 1'b1;
                        end else begin
                            release_held();
                        end
                    end else if (pos + 32'd1 == name_len) begin
                        release_held();
                    end
                end else begin
                    name_char(b);
                end
                if (!halted) begin
                    if (pos + 32'd1 == name_len) close_name();
                    else seg_pos = seg_pos + 32'd1;
                end
            end
            SEG_NAME_PAD, SEG_DATA, SEG_DATA_PAD: begin
                seg_pos = seg_pos + 32'd1;
                if (seg_pos >= seg_len(seg))
                    enter_seg(seg == SEG_DATA_PAD ? SEG_HEADER : seg + 3'd1);
            end
            default: seg = SEG_STOP;
        endcase
        for (k = 0; k < byte_record_n; k++) begin
            r = byte_records[k];
            r.last = (k == byte_record_n - 1);
            pending_records.push_back(r);
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [7:0] rand_nonzero();
        logic [31:0] r;
        r = $urandom_range(255, 1);
        return r[7:0];
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [31:0] r;
        r = $urandom_range(126, 33);
        return r[7:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        if (nib < 4'd10) return 8'h30 + {4'h0, nib};
        return (lower ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
    endfunction

    // size field text with mixed case and, now and then, non-hex characters
    // chosen so the wrapped decode still gives v
    function automatic logic [63:0] encode_hex(input logic [31:0] v);
        logic [63:0] plain;
        logic [63:0] odd;
        logic [31:0] r;
        logic [3:0]  hi;
        int          k;
        for (k = 0; k < 8; k++) begin
            r = $urandom;
            plain[8*k +: 8] = hex_char(v[4*k +: 4], r[0]);
        end
        odd = plain;
        r = $urandom;
        if (r[0] && v[31:28] == 4'h0) begin
            hi = r[7:4];
            odd[63:56] = {hi, 4'h0};
        end
        if (r[1] && v[7:4] != 4'h0) begin
            odd[15:8] = hex_char(v[7:4] - 4'h1, r[2]);
            odd[7:0] = 8'h40 + {4'h0, v[3:0]};
        end else if (r[3] && v[3:0] > 4'h9) begin
            odd[7:0] = 8'h30 + {4'h0, v[3:0]};
        end
        if (hex_text_value(odd) == v) return odd;
        return plain;
    endfunction

    function automatic void add_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) name_buf.push_back(s[k]);
    endfunction

    task automatic set_traffic(input int tx, input int rx);
        tx_idle_pct = tx;
        rx_stall_pct = rx;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        // hold the request until the walker takes it
        s_valid <= 1'b1;
        s_archive_byte <= b;
        do @(posedge aclk); while (!s_ready);
        walk_archive_byte(b);
        walked_items++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_records.size() != 0);
    endtask

    task automatic send_entry(input logic [63:0] size_txt, input logic [63:0] nlen_txt);
        logic [31:0] dsz;
        logic [31:0] nsz;
        int          k;
        dsz = hex_text_value(size_txt);
        nsz = hex_text_value(nlen_txt);
        for (k = 0; k < HDR_LEN; k++) begin
            if (k < 6) send_byte(MAGIC_TEXT[8*(5-k) +: 8]);
            else if (k >= 54 && k <= 61) send_byte(size_txt[8*(61-k) +: 8]);
            else if (k >= 94 && k <= 101) send_byte(nlen_txt[8*(101-k) +: 8]);
            else send_byte(rand_byte());
        end
        for (k = 0; k < nsz; k++) send_byte(name_buf[k]);
        repeat ((4 - ((HDR_LEN + nsz) & 3)) & 3) send_byte(rand_byte());
        repeat (dsz) send_byte(rand_byte());
        repeat ((4 - (dsz & 3)) & 3) send_byte(rand_byte());
    endtask

    function automatic void make_random_name();
        int         style;
        int         len;
        int         k;
        int         p;
        logic [7:0] c;
        name_buf.delete();
        style = $urandom_range(9);
        case (style)
            0, 1, 2, 3: begin
                len = $urandom_range(16, 1);
                repeat (len) name_buf.push_back(rand_text_byte());
                name_buf.push_back(8'h00);
            end
            4: repeat (HOLD_LEN) name_buf.push_back(rand_nonzero());
            5: begin
                if ($urandom_range(1) == 1) begin
                    // one character off the trailer name
                    add_text("TRAILER!!");
                    p = $urandom_range(8);
                    c = name_buf[p] ^ rand_nonzero();
                    name_buf[p] = c;
                    if ($urandom_range(1) == 1) begin
                        add_text("!");
                        name_buf.push_back(8'h00);
                    end
                end else begin
                    len = $urandom_range(8, 1);
                    for (k = 0; k < len; k++) name_buf.push_back(TRAILER_TEXT[8*(8-k) +: 8]);
                end
            end
            6: begin
                len = $urandom_range(14, 2);
                repeat (len) name_buf.push_back(rand_nonzero());
                name_buf[$urandom_range(len - 1)] = 8'h00;
            end
            7: begin
                len = $urandom_range(20, 1);
                repeat (len) name_buf.push_back(rand_byte());
            end
            8: ;
            default: begin
                len = $urandom_range(20, 1);
                repeat (len) name_buf.push_back(rand_nonzero());
            end
        endcase
    endfunction

    task automatic test_empty_name();
        set_traffic(0, 0);
        name_buf.delete();
        send_entry("00000000", "00000000");
    endtask

    task automatic test_short_name();
        // first entry: header plus name lands on a word boundary, so no padding at all
        name_buf.delete();
        add_text("a");
        name_buf.push_back(8'h00);
        send_entry("00000004", "00000002");
        name_buf.delete();
        add_text("xyz");
        send_entry("0000000B", "00000003");
    endtask

    task automatic test_full_hold();
        // nine held bytes released together with the name end
        name_buf.delete();
        name_buf.push_back(8'hFF);
        name_buf.push_back(8'h80);
        name_buf.push_back(8'h01);
        add_text("Qwerty");
        send_entry("0000000a", "00000009");
    endtask

    task automatic test_name_terminator();
        name_buf.delete();
        add_text("x");
        name_buf.push_back(8'h00);
        add_text("yz1234567");
        name_buf.push_back(8'h00);
        send_entry("00000000", "0000000C");
        name_buf.delete();
        name_buf.push_back(8'h00);
        add_text("qrs");
        name_buf.push_back(8'h00);
        send_entry("00000001", "00000005");
    endtask

    task automatic test_trailer_lookalikes();
        name_buf.delete();
        add_text("TRAILER!?");
        name_buf.push_back(8'h00);
        send_entry("00000002", "0000000a");
        name_buf.delete();
        add_text("TRAILER!");
        send_entry("00000000", "00000008");
        name_buf.delete();
        add_text("trailer!!");
        name_buf.push_back(8'h00);
        send_entry("00000003", "0000000A");
    endtask

    task automatic test_hex_variants();
        set_traffic(36, 36);
        name_buf.delete();
        add_text("hexquirk!");
        name_buf.push_back(8'h00);
        send_entry("@000001G", "p000000:");
        name_buf.delete();
        add_text("ab");
        name_buf.push_back(8'h00);
        send_entry("0000001/", " 0000003");
        name_buf.delete();
        add_text("wxyz");
        send_entry("000000aF", "00000004");
    endtask

    task automatic test_random_archive();
        int          entries;
        int          start;
        logic [31:0] dlen;
        entries = 0;
        start = walked_items;
        while (walked_items - start < 380 || entries < 4) begin
            case (entries % 4)
                0: set_traffic(0, 0);
                1: set_traffic(69, 0);
                2: set_traffic(0, 69);
                default: set_traffic(36, 36);
            endcase
            make_random_name();
            if ($urandom_range(7) == 0) dlen = $urandom_range(40);
            else dlen = $urandom_range(12);
            send_entry(encode_hex(dlen), encode_hex(name_buf.size()));
            entries++;
            if (entries == 2) wait_drained();
        end
    endtask

    task automatic test_archive_end();
        int          variant;
        int          k;
        int          p;
        logic [7:0]  b;
        logic [31:0] dlen;
        set_traffic(36, 36);
        variant = $urandom_range(3);
        name_buf.delete();
        if (variant == 3) begin
            // one of the six magic bytes is wrong
            p = $urandom_range(5);
            for (k = 0; k < HDR_LEN; k++) begin
                if (k < 6) begin
                    b = MAGIC_TEXT[8*(5-k) +: 8];
                    if (k == p) b = b ^ rand_nonzero();
                end else begin
                    b = rand_byte();
                end
                send_byte(b);
            end
        end else begin
            add_text("TRAILER!!");
            if (variant == 0) begin
                add_text("!");
                name_buf.push_back(8'h00);
            end else if (variant == 2) begin
                repeat ($urandom_range(5, 1)) name_buf.push_back(rand_byte());
            end
            dlen = $urandom_range(8);
            send_entry(encode_hex(dlen), encode_hex(name_buf.size()));
        end
        // walker has stopped, these must give nothing
        repeat (16) send_byte(rand_byte());
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    walk_record_t oldest;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $display("%0t: record with nothing expected, expected none, actual kind %0d",
                         $time, m_kind);
                errors++;
            end else begin
                oldest = pending_records.pop_front();
                compare_field("kind", {30'd0, oldest.kind}, {30'd0, m_kind});
                compare_field("name_byte", {24'd0, oldest.name_byte}, {24'd0, m_name_byte});
                compare_field("file_size", oldest.file_size, m_file_size);
                compare_field("entry_index", {16'd0, oldest.entry_index},
                              {16'd0, m_entry_index});
                compare_field("last", {31'd0, oldest.last}, {31'd0, m_last});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_run <= 0;
        else idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_name();
        test_short_name();
        test_full_hold();
        test_name_terminator();
        test_trailer_lookalikes();
        test_hex_variants();
        test_random_archive();
        test_archive_end();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/cnw_pkg.sv
design/cnw_parser.sv
design/cnw_emitter.sv
design/cpio_newc_entry_walker_core.sv
design/cnw_checker.sv
dv/testbench.sv
